### hdl/sscb_pkg.sv
// shared types and constants for the sampled segment box collision core
package sscb_pkg;

  localparam int COORD_W  = 16;
  localparam int POS_W    = 18;
  localparam int LIMIT_W  = 15;
  localparam int ACTIVE_W = 4;
  localparam int INDEX_W  = 3;
  localparam int STEP_W   = 4;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 15'd2304;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd0;

  typedef enum logic {
    CMD_QUERY = 1'b0,
    CMD_LOAD  = 1'b1
  } cmd_e;

  typedef enum logic {
    CFG_WORKSPACE_LIMIT = 1'b0,
    CFG_ACTIVE_BOXES    = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_SAMPLE,
    ST_NEXT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic signed [COORD_W-1:0] top;
  } box_t;

  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] index;
    box_t               box;
  } box_wr_t;

endpackage

### hdl/sscb_div.sv
// divider of an unsigned value by a fixed constant through a reciprocal multiply
module sscb_div #(
  parameter int NUM_W = 18,
  parameter int DEN   = 100
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [NUM_W-1:0]        num_i,
  output logic                    busy_o,
  output logic [NUM_W-1:0]        quot_o,
  output logic [$clog2(DEN)-1:0]  rem_o
);
  localparam int REM_W   = $clog2(DEN);
  localparam int SHIFT   = NUM_W + REM_W;
  localparam int RECIP_W = NUM_W + 1;
  localparam int PROD_W  = NUM_W + RECIP_W;
  localparam int QW_W    = PROD_W - SHIFT;
  // rounded-up reciprocal: its excess times any dividend stays below one quotient step
  localparam longint RECIP_L = ((longint'(1) <<< SHIFT) + longint'(DEN) - 1) / longint'(DEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam logic [NUM_W-1:0]   DEN_N = NUM_W'(DEN);

  logic              busy_q, busy_d;
  logic              phase_q, phase_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [NUM_W-1:0]  quot_q, quot_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [PROD_W-1:0] prod;
  logic [QW_W-1:0]   quot_w;
  logic [NUM_W-1:0]  back;

  assign prod   = PROD_W'(num_q) * PROD_W'(RECIP);
  assign quot_w = prod[PROD_W-1:SHIFT];
  assign back   = quot_q * DEN_N;

  // the quotient is registered first, then the remainder is formed from the registered quotient
  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    num_d   = num_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      num_d   = num_i;
    end else if (busy_q) begin
      if (!phase_q) begin
        quot_d  = NUM_W'(quot_w);
        phase_d = 1'b1;
      end else begin
        rem_d   = REM_W'(num_q - back);
        busy_d  = 1'b0;
        phase_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

### hdl/sscb_box_check.sv
// obstacle box table and point test against all active boxes and the workspace limit
module sscb_box_check #(
  parameter int MAX_BOXES = 8
) (
  input  logic                                  clk_i,
  input  sscb_pkg::box_wr_t                     box_wr_i,
  input  logic [sscb_pkg::ACTIVE_W-1:0]         active_boxes_i,
  input  logic [sscb_pkg::LIMIT_W-1:0]          workspace_limit_i,
  input  logic signed [sscb_pkg::POS_W-1:0]     point_x_i,
  input  logic signed [sscb_pkg::POS_W-1:0]     point_y_i,
  output logic                                  hit_o
);
  import sscb_pkg::*;

  box_t                   box_q [MAX_BOXES];
  logic [MAX_BOXES-1:0]   box_hit;
  logic signed [POS_W-1:0] lim_pos;
  logic signed [POS_W-1:0] lim_neg;
  logic                   lim_hit;

  for (genvar k = 0; k < MAX_BOXES; k++) begin : g_box
    always_ff @(posedge clk_i) begin
      if (box_wr_i.en && (32'(box_wr_i.index) == k)) begin
        box_q[k] <= box_wr_i.box;
      end
    end

    // edges inclusive; an inverted box never matches
    assign box_hit[k] = (32'(active_boxes_i) > k)
                     && ($signed(box_q[k].left)   <= point_x_i)
                     && ($signed(box_q[k].right)  >= point_x_i)
                     && ($signed(box_q[k].bottom) <= point_y_i)
                     && ($signed(box_q[k].top)    >= point_y_i);
  end

  assign lim_pos = POS_W'(workspace_limit_i);
  assign lim_neg = -lim_pos;
  assign lim_hit = (point_x_i <= lim_neg) || (point_x_i >= lim_pos)
                || (point_y_i <= lim_neg) || (point_y_i >= lim_pos);

  assign hit_o = (|box_hit) || lim_hit;

endmodule

### hdl/sampled_segment_box_collision_core.sv
// sampled segment versus obstacle box collision core, top level
// load beat: written in the cycle it is accepted, no result; one beat per cycle while idle
// query: the two parallel divisions, then the prep steps that scale the step, then the
// sample points of each pass with a step down between passes, a pass ending at its first
// hit; the result beat waits out any output stall
// reset clears the sequencer, the output valid and the config registers; the box table is not reset
module sampled_segment_box_collision_core #(
  parameter int MAX_BOXES    = 8,
  parameter int SAMPLE_STEPS = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic                                 cfg_index_i,
  input  logic [sscb_pkg::LIMIT_W-1:0]         cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 cmd_i,
  input  logic [sscb_pkg::INDEX_W-1:0]         box_index_i,
  input  logic signed [sscb_pkg::COORD_W-1:0]  box_left_i,
  input  logic signed [sscb_pkg::COORD_W-1:0]  box_right_i,
  input  logic signed [sscb_pkg::COORD_W-1:0]  box_bottom_i,
  input  logic signed [sscb_pkg::COORD_W-1:0]  box_top_i,
  input  logic signed [sscb_pkg::COORD_W-1:0]  start_x_i,
  input  logic signed [sscb_pkg::COORD_W-1:0]  start_y_i,
  input  logic signed [sscb_pkg::COORD_W-1:0]  end_x_i,
  input  logic signed [sscb_pkg::COORD_W-1:0]  end_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 path_blocked_o,
  output logic                                 clear_found_o,
  output logic [sscb_pkg::STEP_W-1:0]          reach_step_o,
  output logic signed [sscb_pkg::COORD_W-1:0]  reach_x_o,
  output logic signed [sscb_pkg::COORD_W-1:0]  reach_y_o
);
  import sscb_pkg::*;

  localparam int DEN   = SAMPLE_STEPS * SAMPLE_STEPS;
  localparam int REM_W = $clog2(DEN);
  localparam int CNT_W = $clog2(SAMPLE_STEPS + 1);
  localparam int OFS_C = (65536 + DEN - 1) / DEN;
  localparam int NUM_W = $clog2(65536 + OFS_C * DEN);
  localparam logic [REM_W:0]   DEN_V  = (REM_W+1)'(DEN);
  localparam logic [CNT_W-1:0] LAST_J = CNT_W'(SAMPLE_STEPS - 1);
  localparam logic [CNT_W-1:0] FULL_I = CNT_W'(SAMPLE_STEPS);

  // value held as q + r/DEN with 0 <= r < DEN
  typedef struct packed {
    logic signed [POS_W-1:0] q;
    logic [REM_W-1:0]        r;
  } nval_t;

  function automatic nval_t nadd(input nval_t x, input nval_t y, input logic sub);
    logic [REM_W:0]          rs;
    logic signed [POS_W-1:0] qs;
    logic                    adj;
    nval_t                   res;
    if (sub) begin
      rs  = {1'b0, x.r} - {1'b0, y.r};
      adj = rs[REM_W];
      qs  = x.q - y.q - POS_W'(adj);
      if (adj) begin
        rs = rs + DEN_V;
      end
    end else begin
      rs  = {1'b0, x.r} + {1'b0, y.r};
      adj = (rs >= DEN_V);
      qs  = x.q + y.q + POS_W'(adj);
      if (adj) begin
        rs = rs - DEN_V;
      end
    end
    res.q = qs;
    res.r = rs[REM_W-1:0];
    return res;
  endfunction

  state_e                  state_q, state_d;
  logic [LIMIT_W-1:0]      limit_q, limit_d;
  logic [ACTIVE_W-1:0]     active_q, active_d;
  logic [CNT_W-1:0]        i_q, i_d;
  logic [CNT_W-1:0]        j_q, j_d;
  logic signed [COORD_W-1:0] start_q [2];
  logic signed [COORD_W-1:0] start_d [2];
  nval_t                   a_q [2];
  nval_t                   a_d [2];
  nval_t                   pos_q [2];
  nval_t                   pos_d [2];
  nval_t                   d_w [2];
  nval_t                   op_a [2];
  nval_t                   op_b [2];
  nval_t                   sum_w [2];
  logic signed [COORD_W-1:0] in_start [2];
  logic signed [COORD_W-1:0] in_end [2];
  logic [NUM_W-1:0]        div_num [2];
  logic [NUM_W-1:0]        div_quot [2];
  logic [REM_W-1:0]        div_rem [2];
  logic [1:0]              div_busy;
  logic                    in_fire, query_fire, out_free, hit;
  box_wr_t                 box_wr;

  logic                    blocked_q, blocked_d;
  logic                    found_q, found_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic signed [COORD_W-1:0] rx_q, rx_d, ry_q, ry_d;

  logic                    out_valid_q, out_valid_d;
  logic                    out_blocked_q, out_blocked_d;
  logic                    out_found_q, out_found_d;
  logic [STEP_W-1:0]       out_step_q, out_step_d;
  logic signed [COORD_W-1:0] out_x_q, out_x_d, out_y_q, out_y_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign query_fire  = in_fire && (cmd_e'(cmd_i) == CMD_QUERY);
  assign out_free    = !out_valid_q || out_ready_i;

  assign in_start[0] = start_x_i;
  assign in_start[1] = start_y_i;
  assign in_end[0]   = end_x_i;
  assign in_end[1]   = end_y_i;

  // offset keeps the dividend positive so floor division needs no sign fix-up
  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign div_num[l] = NUM_W'(32'(in_end[l]) - 32'(in_start[l]) + OFS_C * DEN);

    sscb_div #(
      .NUM_W (NUM_W),
      .DEN   (DEN)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (query_fire),
      .num_i   (div_num[l]),
      .busy_o  (div_busy[l]),
      .quot_o  (div_quot[l]),
      .rem_o   (div_rem[l])
    );

    assign d_w[l].q = POS_W'(div_quot[l]) - POS_W'(OFS_C);
    assign d_w[l].r = div_rem[l];

    // shared adder: step scaling and step down on a, sample walk on pos
    assign op_a[l]  = (state_q == ST_SAMPLE) ? pos_q[l] : a_q[l];
    assign op_b[l]  = (state_q == ST_SAMPLE) ? a_q[l] : d_w[l];
    assign sum_w[l] = nadd(op_a[l], op_b[l], (state_q == ST_NEXT));
  end

  assign box_wr.en         = in_fire && (cmd_e'(cmd_i) == CMD_LOAD);
  assign box_wr.index      = box_index_i;
  assign box_wr.box.left   = box_left_i;
  assign box_wr.box.right  = box_right_i;
  assign box_wr.box.bottom = box_bottom_i;
  assign box_wr.box.top    = box_top_i;

  sscb_box_check #(
    .MAX_BOXES (MAX_BOXES)
  ) u_box_check (
    .clk_i             (clk_i),
    .box_wr_i          (box_wr),
    .active_boxes_i    (active_q),
    .workspace_limit_i (limit_q),
    .point_x_i         (sum_w[0].q),
    .point_y_i         (sum_w[1].q),
    .hit_o             (hit)
  );

  always_comb begin
    limit_d  = limit_q;
    active_d = active_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_WORKSPACE_LIMIT: limit_d  = cfg_data_i;
        CFG_ACTIVE_BOXES:    active_d = cfg_data_i[ACTIVE_W-1:0];
        default:             limit_d  = limit_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (query_fire) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_busy == '0) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (j_q == LAST_J) begin
          state_d = ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        if (hit) begin
          state_d = (i_q == '0) ? ST_DONE : ST_NEXT;
        end else if (j_q == LAST_J) begin
          state_d = (i_q == FULL_I) ? ST_NEXT : ST_DONE;
        end
      end
      ST_NEXT: state_d = ST_SAMPLE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    i_d       = i_q;
    j_d       = j_q;
    start_d   = start_q;
    a_d       = a_q;
    pos_d     = pos_q;
    blocked_d = blocked_q;
    found_d   = found_q;
    step_d    = step_q;
    rx_d      = rx_q;
    ry_d      = ry_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_blocked_d = out_blocked_q;
    out_found_d   = out_found_q;
    out_step_d    = out_step_q;
    out_x_d       = out_x_q;
    out_y_d       = out_y_q;
    case (state_q)
      ST_IDLE: begin
        if (query_fire) begin
          start_d = in_start;
          j_d     = '0;
          a_d[0]  = '0;
          a_d[1]  = '0;
        end
      end
      ST_PREP: begin
        // a becomes SAMPLE_STEPS times the divided difference, the per-step increment
        a_d = sum_w;
        j_d = j_q + CNT_W'(1);
        if (j_q == LAST_J) begin
          j_d = '0;
          i_d = FULL_I;
          for (int l = 0; l < 2; l++) begin
            pos_d[l].q = POS_W'(start_q[l]);
            pos_d[l].r = '0;
          end
        end
      end
      ST_SAMPLE: begin
        pos_d = sum_w;
        j_d   = j_q + CNT_W'(1);
        if (hit) begin
          if (i_q == FULL_I) begin
            blocked_d = 1'b1;
          end
          if (i_q == '0) begin
            found_d = 1'b0;
            step_d  = '0;
            rx_d    = start_q[0];
            ry_d    = start_q[1];
          end
        end else if (j_q == LAST_J) begin
          if (i_q == FULL_I) begin
            blocked_d = 1'b0;
          end else begin
            // last sample of a pass lies exactly on the step point
            found_d = 1'b1;
            step_d  = STEP_W'(i_q);
            rx_d    = sum_w[0].q[COORD_W-1:0];
            ry_d    = sum_w[1].q[COORD_W-1:0];
          end
        end
      end
      ST_NEXT: begin
        a_d = sum_w;
        i_d = i_q - CNT_W'(1);
        j_d = '0;
        for (int l = 0; l < 2; l++) begin
          pos_d[l].q = POS_W'(start_q[l]);
          pos_d[l].r = '0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_blocked_d = blocked_q;
          out_found_d   = found_q;
          out_step_d    = step_q;
          out_x_d       = rx_q;
          out_y_d       = ry_q;
        end
      end
      default: begin
        j_d = j_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= LIMIT_RESET;
      active_q    <= ACTIVE_RESET;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      active_q    <= active_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q       <= start_d;
    a_q           <= a_d;
    pos_q         <= pos_d;
    blocked_q     <= blocked_d;
    found_q       <= found_d;
    step_q        <= step_d;
    rx_q          <= rx_d;
    ry_q          <= ry_d;
    out_blocked_q <= out_blocked_d;
    out_found_q   <= out_found_d;
    out_step_q    <= out_step_d;
    out_x_q       <= out_x_d;
    out_y_q       <= out_y_d;
  end

  assign out_valid_o    = out_valid_q;
  assign path_blocked_o = out_blocked_q;
  assign clear_found_o  = out_found_q;
  assign reach_step_o   = out_step_q;
  assign reach_x_o      = out_x_q;
  assign reach_y_o      = out_y_q;

endmodule
